// ===== sv/tsdc_pkg.sv =====
// Shared types, constants and functions for the temperature scratchpad decoder.
// No dependencies; every other file imports this package.
`default_nettype none
package tsdc_pkg;
	localparam logic [7:0] LEGACY_FAMILY = 8'h10;
	localparam logic [7:0] LEGACY_CPD = 8'h10;
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [1:0] RES_9BIT = 2'd0;
	localparam logic [1:0] RES_10BIT = 2'd1;
	localparam logic [1:0] RES_11BIT = 2'd2;
	localparam int DIV_NUM_W = 33;
	localparam int DIV_DEN_W = 17;
	localparam logic [2:0] REG_CAL_ENABLE = 3'd0;
	localparam logic [2:0] REG_RAW_LOW = 3'd1;
	localparam logic [2:0] REG_REF_LOW = 3'd2;
	localparam logic [2:0] REG_RAW_HIGH = 3'd3;
	localparam logic [2:0] REG_REF_HIGH = 3'd4;
	localparam logic [2:0] REG_FAMILY = 3'd5;

	typedef struct packed {
		logic ok;
		logic bypass;
		logic neg;
		logic signed [15:0] raw;
	} tag_t;

	function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] x_in);
		logic [7:0] crc;
		logic [7:0] x;
		crc = crc_in;
		x = x_in;
		for (int k = 0; k < 8; k++) begin
			if (crc[0] ^ x[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
			x = x >> 1;
		end
		return crc;
	endfunction
endpackage
`default_nettype wire

// ===== sv/temp_scratchpad_decode_calibrate.sv =====
// Top level: APB register file, decode, multiply, divider and saturation stages.
// Depends on tsdc_pkg, tsdc_decode and tsdc_div.
//
// One scratchpad item may be started in every clock cycle; busy is never high.
// Each item yields exactly one result; the divider on its path resolves
// one quotient bit per pipeline stage. The result is shown for one cycle with
// done high and cannot be held off. Registers may be written only while no
// item is in flight.
`default_nettype none
module temp_scratchpad_decode_calibrate import tsdc_pkg::*; #(
	parameter int NW = DIV_NUM_W,
	parameter int DW = DIV_DEN_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [7:0] scratch_byte0,
	input wire logic [7:0] scratch_byte1,
	input wire logic [7:0] scratch_byte2,
	input wire logic [7:0] scratch_byte3,
	input wire logic [7:0] scratch_byte4,
	input wire logic [7:0] scratch_byte5,
	input wire logic [7:0] scratch_byte6,
	input wire logic [7:0] scratch_byte7,
	input wire logic [7:0] scratch_crc,
	output logic done,
	output logic crc_ok,
	output logic signed [15:0] raw_temp,
	output logic signed [15:0] temperature,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic cal_en_q;
	logic signed [15:0] raw_low_q, ref_low_q, raw_high_q, ref_high_q;
	logic [7:0] family_q;
	logic [2:0] reg_idx;

	assign busy = 1'b0;
	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_en_q <= 1'b0;
			raw_low_q <= 16'sd0;
			ref_low_q <= 16'sd0;
			raw_high_q <= 16'sd1600;
			ref_high_q <= 16'sd1600;
			family_q <= 8'd0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_CAL_ENABLE: cal_en_q <= pwdata[0];
				REG_RAW_LOW: raw_low_q <= pwdata[15:0];
				REG_REF_LOW: ref_low_q <= pwdata[15:0];
				REG_RAW_HIGH: raw_high_q <= pwdata[15:0];
				REG_REF_HIGH: ref_high_q <= pwdata[15:0];
				REG_FAMILY: family_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CAL_ENABLE: prdata = {31'd0, cal_en_q};
			REG_RAW_LOW: prdata = {{16{raw_low_q[15]}}, raw_low_q};
			REG_REF_LOW: prdata = {{16{ref_low_q[15]}}, ref_low_q};
			REG_RAW_HIGH: prdata = {{16{raw_high_q[15]}}, raw_high_q};
			REG_REF_HIGH: prdata = {{16{ref_high_q[15]}}, ref_high_q};
			REG_FAMILY: prdata = {24'd0, family_q};
			default: prdata = 32'd0;
		endcase
	end

	logic dec_valid, dec_ok;
	logic signed [15:0] dec_raw;

	tsdc_decode u_decode (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.b0(scratch_byte0), .b1(scratch_byte1), .b2(scratch_byte2), .b3(scratch_byte3),
		.b4(scratch_byte4), .b5(scratch_byte5), .b6(scratch_byte6), .b7(scratch_byte7),
		.crc_in(scratch_crc), .family(family_q),
		.out_valid(dec_valid), .out_ok(dec_ok), .out_raw(dec_raw)
	);

	logic signed [16:0] span, range_v;
	assign span = 17'(raw_high_q) - 17'(raw_low_q);
	assign range_v = 17'(ref_high_q) - 17'(ref_low_q);

	logic valid_s3, ok_s3, byp_s3;
	logic signed [15:0] raw_s3;
	logic signed [16:0] diff_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= dec_valid;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3 <= dec_ok;
		byp_s3 <= !cal_en_q || (span == 17'sd0);
		raw_s3 <= dec_raw;
		diff_s3 <= 17'(dec_raw) - 17'(raw_low_q);
	end

	logic valid_s4, ok_s4, byp_s4;
	logic signed [15:0] raw_s4;
	logic signed [33:0] prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4 <= ok_s3;
		byp_s4 <= byp_s3;
		raw_s4 <= raw_s3;
		prod_s4 <= 34'(diff_s3) * 34'(range_v);
	end

	logic [33:0] prod_mag;
	logic [16:0] span_mag;
	tag_t div_tag_in, div_tag_out;
	logic div_valid;
	logic [NW-1:0] quot;

	assign prod_mag = prod_s4[33] ? 34'(-prod_s4) : prod_s4;
	assign span_mag = span[16] ? 17'(-span) : span;
	assign div_tag_in = '{ok: ok_s4, bypass: byp_s4, neg: prod_s4[33] ^ span[16], raw: raw_s4};

	tsdc_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s4),
		.num(NW'(prod_mag)), .den(DW'(span_mag)), .in_tag(div_tag_in),
		.out_valid(div_valid), .quot(quot), .out_tag(div_tag_out)
	);

	logic signed [NW:0] qs;
	logic signed [NW+1:0] sum;
	logic signed [15:0] cal;

	always_comb begin
		qs = div_tag_out.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		sum = (NW+2)'(ref_low_q) + (NW+2)'(qs);
		if (sum > (NW+2)'(32767)) begin
			cal = 16'sh7FFF;
		end else if (sum < -(NW+2)'(32768)) begin
			cal = -16'sh8000;
		end else begin
			cal = sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		crc_ok <= div_tag_out.ok;
		if (!div_tag_out.ok) begin
			raw_temp <= 16'sd0;
			temperature <= 16'sd0;
		end else begin
			raw_temp <= div_tag_out.raw;
			temperature <= div_tag_out.bypass ? div_tag_out.raw : cal;
		end
	end
endmodule
`default_nettype wire

// ===== sv/tsdc_decode.sv =====
// Two pipeline stages: CRC-8 check over the scratchpad and raw reading decode.
// Depends on tsdc_pkg.
`default_nettype none
module tsdc_decode import tsdc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [7:0] b0,
	input wire logic [7:0] b1,
	input wire logic [7:0] b2,
	input wire logic [7:0] b3,
	input wire logic [7:0] b4,
	input wire logic [7:0] b5,
	input wire logic [7:0] b6,
	input wire logic [7:0] b7,
	input wire logic [7:0] crc_in,
	input wire logic [7:0] family,
	output logic out_valid,
	output logic out_ok,
	output logic signed [15:0] out_raw
);
	logic valid_s1;
	logic [7:0] crc_s1, b4_s1, b5_s1, b6_s1, b7_s1, crcin_s1;
	logic signed [15:0] rd_s1;
	logic [7:0] crc_all;
	logic signed [19:0] v8, vleg;
	logic signed [15:0] raw_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		crc_s1 <= crc_byte(crc_byte(crc_byte(crc_byte(8'h00, b0), b1), b2), b3);
		rd_s1 <= $signed({b1, b0});
		b4_s1 <= b4;
		b5_s1 <= b5;
		b6_s1 <= b6;
		b7_s1 <= b7;
		crcin_s1 <= crc_in;
	end

	always_comb begin
		crc_all = crc_byte(crc_byte(crc_byte(crc_byte(crc_s1, b4_s1), b5_s1), b6_s1), b7_s1);
		v8 = {{1{rd_s1[15]}}, rd_s1, 3'b000};
		if (b7_s1 == LEGACY_CPD) begin
			vleg = {v8[19:4], 4'b0000} + 20'sd12 - $signed({12'd0, b6_s1});
		end else begin
			vleg = v8;
		end
		if (family == LEGACY_FAMILY) begin
			if (vleg > 20'sd32767) begin
				raw_d = 16'sh7FFF;
			end else if (vleg < -20'sd32768) begin
				raw_d = -16'sh8000;
			end else begin
				raw_d = vleg[15:0];
			end
		end else begin
			case (b4_s1[6:5])
				RES_9BIT: raw_d = {rd_s1[15:3], 3'b000};
				RES_10BIT: raw_d = {rd_s1[15:2], 2'b00};
				RES_11BIT: raw_d = {rd_s1[15:1], 1'b0};
				default: raw_d = rd_s1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_ok <= (crc_all == crcin_s1);
		out_raw <= raw_d;
	end
endmodule
`default_nettype wire

// ===== sv/tsdc_div.sv =====
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
// Depends on tsdc_pkg for the tag type carried alongside each item.
`default_nettype none
module tsdc_div import tsdc_pkg::*; #(
	parameter int NW = DIV_NUM_W,
	parameter int DW = DIV_DEN_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [NW-1:0] num,
	input wire logic [DW-1:0] den,
	input wire tag_t in_tag,
	output logic out_valid,
	output logic [NW-1:0] quot,
	output tag_t out_tag
);
	logic v_s [0:NW];
	logic [NW-1:0] n_s [0:NW];
	logic [NW-1:0] q_s [0:NW];
	logic [DW-1:0] r_s [0:NW];
	tag_t t_s [0:NW];

	assign v_s[0] = in_valid;
	assign n_s[0] = num;
	assign q_s[0] = '0;
	assign r_s[0] = '0;
	assign t_s[0] = in_tag;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] trial;
		logic fits;
		assign trial = {r_s[i], n_s[i][NW-1]};
		assign fits = trial >= {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (fits) begin
				r_s[i+1] <= DW'(trial - {1'b0, den});
			end else begin
				r_s[i+1] <= trial[DW-1:0];
			end
			q_s[i+1] <= {q_s[i][NW-2:0], fits};
			n_s[i+1] <= {n_s[i][NW-2:0], 1'b0};
			t_s[i+1] <= t_s[i];
		end
	end

	assign out_valid = v_s[NW];
	assign quot = q_s[NW];
	assign out_tag = t_s[NW];
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for temp_scratchpad_decode_calibrate: scratchpad items with
// valid and corrupted CRCs are decoded under several calibration and family settings.
// Depends on tsdc_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb;
	import tsdc_pkg::*;

	typedef struct {
		logic ok;
		logic signed [15:0] raw;
		logic signed [15:0] temp;
	} reading_t;

	class reading_board;
		reading_t pending[$];
		int mismatches;

		function void note(reading_t r);
			pending.insert(pending.size(), r);
		endfunction

		function void check(logic ok, logic signed [15:0] raw, logic signed [15:0] temp);
			reading_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: ok=%0d raw=%0d temp=%0d", ok, raw, temp);
				return;
			end
			e = pending.pop_front();
			if (ok !== e.ok || raw !== e.raw || temp !== e.temp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected ok=%0d raw=%0d temp=%0d, got ok=%0d raw=%0d temp=%0d",
						e.ok, e.raw, e.temp, ok, raw, temp);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, crc_ok, psel, penable, pwrite, pready;
	logic [7:0] sb[9];
	logic signed [15:0] raw_temp, temperature;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	logic cfg_en;
	logic signed [15:0] cfg_raw_lo, cfg_ref_lo, cfg_raw_hi, cfg_ref_hi;
	logic [7:0] cfg_family;
	reading_board board;

	temp_scratchpad_decode_calibrate dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.scratch_byte0(sb[0]), .scratch_byte1(sb[1]), .scratch_byte2(sb[2]),
		.scratch_byte3(sb[3]), .scratch_byte4(sb[4]), .scratch_byte5(sb[5]),
		.scratch_byte6(sb[6]), .scratch_byte7(sb[7]), .scratch_crc(sb[8]),
		.done(done), .crc_ok(crc_ok), .raw_temp(raw_temp), .temperature(temperature),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [7:0] maxim_crc(logic [7:0] b[9]);
		logic [7:0] c;
		logic [7:0] x;
		c = 0;
		for (int i = 0; i < 8; i++) begin
			x = b[i];
			for (int k = 0; k < 8; k++) begin
				c = ((c[0] ^ x[0]) != 0) ? ((c >> 1) ^ 8'h8C) : (c >> 1);
				x = x >> 1;
			end
		end
		return c;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic reading_t decode_reading(logic [7:0] b[9]);
		reading_t r;
		longint v, span, num;
		r.ok = 0;
		r.raw = 0;
		r.temp = 0;
		if (maxim_crc(b) != b[8]) return r;
		v = longint'($signed({b[1], b[0]}));
		if (cfg_family == LEGACY_FAMILY) begin
			v = v * 8;
			if (b[7] == LEGACY_CPD) v = (v - (v & 15)) + 12 - longint'(b[6]);
			v = clamp16(v);
		end else begin
			case (b[4][6:5])
				RES_9BIT: v = v - (v & 7);
				RES_10BIT: v = v - (v & 3);
				RES_11BIT: v = v - (v & 1);
				default: ;
			endcase
		end
		r.ok = 1;
		r.raw = v[15:0];
		r.temp = v[15:0];
		if (cfg_en) begin
			span = longint'(cfg_raw_hi) - longint'(cfg_raw_lo);
			if (span != 0) begin
				num = (v - longint'(cfg_raw_lo)) * (longint'(cfg_ref_hi) - longint'(cfg_ref_lo));
				r.temp = clamp16(longint'(cfg_ref_lo) + num / span);
			end
		end
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0, val};
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_CAL_ENABLE: cfg_en = val[0];
			REG_RAW_LOW: cfg_raw_lo = val;
			REG_REF_LOW: cfg_ref_lo = val;
			REG_RAW_HIGH: cfg_raw_hi = val;
			REG_REF_HIGH: cfg_ref_hi = val;
			REG_FAMILY: cfg_family = val[7:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic en, logic [15:0] rl, logic [15:0] fl, logic [15:0] rh,
			logic [15:0] fh, logic [7:0] fam);
		int guard;
		guard = 0;
		start <= 0;
		while (board.pending.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (45) @(posedge clk);
		write_reg(REG_CAL_ENABLE, {15'h0, en});
		write_reg(REG_RAW_LOW, rl);
		write_reg(REG_REF_LOW, fl);
		write_reg(REG_RAW_HIGH, rh);
		write_reg(REG_REF_HIGH, fh);
		write_reg(REG_FAMILY, {8'h0, fam});
	endtask

	task automatic send_item(logic [7:0] b[9]);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		for (int i = 0; i < 9; i++) sb[i] <= b[i];
		do @(posedge clk); while (busy);
		board.note(decode_reading(b));
	endtask

	task automatic send_random(int n, int bad_pct);
		logic [7:0] b[9];
		for (int j = 0; j < n; j++) begin
			for (int i = 0; i < 9; i++) b[i] = $urandom_range(0, 255);
			case ($urandom_range(0, 5))
				0: b[7] = LEGACY_CPD;
				1: begin b[0] = $urandom_range(0, 1) ? 8'h00 : 8'hFF; b[1] = b[0] ^ 8'h80; end
				default: ;
			endcase
			if ($urandom_range(0, 99) >= bad_pct) b[8] = maxim_crc(b);
			send_item(b);
		end
	endtask

	task automatic send_directed();
		logic [7:0] b[9];
		logic [7:0] lo[6] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h7F, 8'h55};
		logic [7:0] hi[6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hAA};
		for (int j = 0; j < 6; j++) begin
			for (int r = 0; r < 4; r++) begin
				for (int i = 0; i < 9; i++) b[i] = $urandom_range(0, 255);
				b[0] = lo[j];
				b[1] = hi[j];
				b[4] = {1'b0, r[1:0], 5'h1F};
				b[6] = (r == 0) ? 8'h00 : 8'hFF;
				b[7] = (r < 2) ? LEGACY_CPD : 8'hFF;
				b[8] = maxim_crc(b);
				if (r == 3 && j > 3) b[8] = ~b[8];
				send_item(b);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) board.check(crc_ok, raw_temp, temperature);
	end

	initial begin
		int guard;
		board = new();
		arst_n = 0;
		start = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		for (int i = 0; i < 9; i++) sb[i] = 0;
		cfg_en = 0;
		cfg_raw_lo = 0;
		cfg_ref_lo = 0;
		cfg_raw_hi = 1600;
		cfg_ref_hi = 1600;
		cfg_family = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_directed();
		send_random(60, 20);
		configure(1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, LEGACY_FAMILY);
		send_directed();
		send_random(80, 15);
		configure(1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 8'h00);
		send_random(80, 15);
		configure(1, 16'd100, 16'd50, 16'd100, 16'd900, 8'hFF);
		send_random(40, 15);
		configure(1, 16'hFFF0, 16'd320, 16'd1640, 16'hFF00, LEGACY_FAMILY);
		send_random(100, 15);
		configure(1, 16'd3, 16'h8000, 16'd4, 16'h7FFF, 8'h28);
		send_random(80, 15);
		configure(0, 16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0, 8'hEF);
		send_random(60, 15);
		start <= 0;
		guard = 0;
		while (board.pending.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (45) @(posedge clk);
		if (board.pending.size() == 0 && board.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

// ===== temp_scratchpad_decode_calibrate.f =====
sv/tsdc_pkg.sv
sv/tsdc_decode.sv
sv/tsdc_div.sv
sv/temp_scratchpad_decode_calibrate.sv
test/tb.sv
